FILE: design/assert_macros.svh
// assertion helpers used by keyed_record_table_with_expiry
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property that must hold at every clock edge outside reset
`define KRT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in this cycle implies a property in the next one
`define KRT_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define KRT_ASSERT(label, clk, rst, prop, msg)

`define KRT_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

FILE: design/krt_pkg.sv
package krt_pkg;

  localparam int CNT_W = 6;

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_SET    = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_SWEEP  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_LOGIC    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key;
    logic [31:0] score;
    logic [31:0] expiry;
    logic [63:0] payload;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        has_record;
    logic        expired;
    logic [31:0] out_key;
    logic [31:0] out_score;
    logic [31:0] out_expiry;
    logic [63:0] out_payload;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] score;
    logic [31:0] expiry;
    logic [63:0] payload;
  } rec_t;

endpackage

FILE: design/keyed_record_table_with_expiry.sv
// Keyed record table with expiry.
// Request channel: req_valid / req_stall / req. A request is taken when req_valid is
// high and req_stall is low; req_stall is high while a request is being worked on.
// Response channel: rsp_valid / rsp_stall / rsp, driven from an output register,
// so a new request can be taken while the last response still waits.
// Add, set and lookup scan the table from slot 0, one slot per cycle out of the
// record memory; each response is sent once the key is found or every stored record
// has been read, and the next request can be taken once the block is idle again.
// Sweep reads each slot once and, for each removed record that is not the last one,
// moves the last record into the freed slot, which is then checked again. It sends
// one response per kept or expired record and a final response with last set.
// The record memory has one read port and a single write port.
// Reset empties the table (the record count goes to zero) and drops any pending
// response; memory contents are not cleared.
// While rsp_valid and rsp_stall are both high the response register holds and the
// scan waits at the next response it has to send.
`include "assert_macros.svh"

module keyed_record_table_with_expiry #(
  parameter int TABLE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  krt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output krt_pkg::rsp_t rsp
);
  import krt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_SCHK = 3'd2;
  localparam logic [2:0] S_SMOV = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  rec_t mem [TABLE_DEPTH];
  rec_t rdata;

  logic [2:0]       state, state_next;
  req_t             cur;
  logic [CNT_W-1:0] pos, pos_next;
  logic             chk_v, chk_v_next;
  logic [CNT_W-1:0] count, count_next;

  logic             rd_en;
  logic [IDX_W-1:0] raddr;
  logic             we;
  logic [IDX_W-1:0] waddr;
  rec_t             wdata;
  logic             emit;
  rsp_t             emit_data;

  logic             out_free;
  logic             accept;
  logic             found, missed;
  logic             is_exp, is_zero;
  logic [CNT_W-1:0] pos_prev, pos_inc, last_idx;
  rec_t             new_rec;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign pos_prev  = pos - 1'b1;
  assign pos_inc   = pos + 1'b1;
  assign last_idx  = count - 1'b1;
  assign found     = chk_v && (rdata.key == cur.key);
  assign missed    = (chk_v && pos == count) || (!chk_v && count == '0);
  assign is_exp    = rdata.expiry <= cur.now_time;
  assign is_zero   = rdata.key == '0;

  always_comb begin
    new_rec.key     = cur.key;
    new_rec.score   = cur.score;
    new_rec.expiry  = cur.expiry;
    new_rec.payload = cur.payload;
  end

  always_comb begin
    state_next = state;
    pos_next   = pos;
    chk_v_next = chk_v;
    count_next = count;
    rd_en      = 1'b0;
    raddr      = pos[IDX_W-1:0];
    we         = 1'b0;
    waddr      = pos[IDX_W-1:0];
    wdata      = rdata;
    emit       = 1'b0;
    emit_data  = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          pos_next   = '0;
          chk_v_next = 1'b0;
          if (req.req_type == REQ_SWEEP) begin
            if (count == '0) begin
              state_next = S_FIN;
            end else begin
              rd_en      = 1'b1;
              raddr      = '0;
              state_next = S_SCHK;
            end
          end else begin
            state_next = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (found || missed) begin
          if (out_free) begin
            emit           = 1'b1;
            emit_data.last = 1'b1;
            state_next     = S_IDLE;
            case (cur.req_type)
              REQ_LOOKUP: begin
                if (found) begin
                  emit_data.status      = ST_OK;
                  emit_data.has_record  = 1'b1;
                  emit_data.out_key     = rdata.key;
                  emit_data.out_score   = rdata.score;
                  emit_data.out_expiry  = rdata.expiry;
                  emit_data.out_payload = rdata.payload;
                end else begin
                  emit_data.status = ST_NOTFOUND;
                end
              end
              REQ_SET: begin
                if (found && rdata.score < cur.score) begin
                  we               = 1'b1;
                  waddr            = pos_prev[IDX_W-1:0];
                  wdata            = new_rec;
                  emit_data.status = ST_OK;
                end else begin
                  emit_data.status = ST_LOGIC;
                end
              end
              default: begin
                if (found) begin
                  emit_data.status = ST_LOGIC;
                end else if (count >= DEPTH_C) begin
                  emit_data.status = ST_FULL;
                end else begin
                  we               = 1'b1;
                  waddr            = count[IDX_W-1:0];
                  wdata            = new_rec;
                  count_next       = count + 1'b1;
                  emit_data.status = ST_OK;
                end
              end
            endcase
          end
        end else begin
          // read slot pos now, compare it next cycle
          rd_en      = 1'b1;
          raddr      = pos[IDX_W-1:0];
          chk_v_next = 1'b1;
          pos_next   = pos_inc;
        end
      end
      S_SCHK: begin
        if (is_exp || is_zero) begin
          if (!is_exp || out_free) begin
            if (is_exp) begin
              emit                  = 1'b1;
              emit_data.status      = ST_OK;
              emit_data.has_record  = 1'b1;
              emit_data.expired     = 1'b1;
              emit_data.out_key     = rdata.key;
              emit_data.out_score   = rdata.score;
              emit_data.out_expiry  = rdata.expiry;
              emit_data.out_payload = rdata.payload;
            end
            if (pos == last_idx) begin
              count_next = last_idx;
              state_next = S_FIN;
            end else begin
              // fetch the last record to fill the hole
              rd_en      = 1'b1;
              raddr      = last_idx[IDX_W-1:0];
              state_next = S_SMOV;
            end
          end
        end else if (out_free) begin
          emit                  = 1'b1;
          emit_data.status      = ST_OK;
          emit_data.has_record  = 1'b1;
          emit_data.out_key     = rdata.key;
          emit_data.out_score   = rdata.score;
          emit_data.out_expiry  = rdata.expiry;
          emit_data.out_payload = rdata.payload;
          pos_next              = pos_inc;
          if (pos_inc < count) begin
            rd_en = 1'b1;
            raddr = pos_inc[IDX_W-1:0];
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_SMOV: begin
        // moved record stays in rdata and is checked again in its new slot
        we         = 1'b1;
        waddr      = pos[IDX_W-1:0];
        wdata      = rdata;
        count_next = last_idx;
        state_next = S_SCHK;
      end
      S_FIN: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_data.status = ST_OK;
          emit_data.last   = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      chk_v     <= 1'b0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      chk_v <= chk_v_next;
      count <= count_next;
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= req;
    end
    if (emit) begin
      rsp <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  `KRT_ASSERT(a_count_bound, clk, rst, count <= DEPTH_C, "record count above table depth")
  `KRT_ASSERT(a_srch_range, clk, rst, !(state == S_SRCH && chk_v) || pos <= count, "search ran past the stored records")
  `KRT_ASSERT(a_move_src, clk, rst, state != S_SMOV || ({1'b0, pos} + 7'd1) < {1'b0, count}, "move source is not a later slot")
  `KRT_ASSERT_NEXT(a_sweep_shrink, clk, rst, state == S_SCHK || state == S_SMOV, count <= $past(count), "sweep grew the table")

endmodule
